// File: sv/ccb_pkg.sv
// Shared types and constants for the circular capture buffer.
package ccb_pkg;

    localparam int SAMPLE_W = 32;
    localparam int FRAC_W   = 8;
    localparam int TALLY_W  = 7;
    localparam int CMD_W    = 2;

    localparam logic KIND_DUMP  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_COUNT  = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t                cmd;
        logic [SAMPLE_W-1:0] sample;
    } op_t;

    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] value;
        logic [TALLY_W-1:0]  tally;
        logic                last;
    } res_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_DUMP = 1'b1
    } bk_state_t;

endpackage

// File: sv/ccb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ccb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/ccb_front.sv
// Input side: accepts items, drops fractional samples in integer-only mode, queues commands.
module ccb_front
    import ccb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // sample
    input  logic [CMD_W-1:0]    s_tuser,   // command
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,  // integer_only
    output logic                q_valid,
    output op_t                 q_op,
    input  logic                q_ready
);

    localparam int QDEPTH = 2;

    logic       integer_only_reg;
    op_t        queue_mem [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept, drop, push, pop;
    cmd_t       cmd;

    assign cfg_ready = 1'b1;
    assign cmd       = cmd_t'(s_tuser);
    assign s_tready  = (count_reg != 2'(QDEPTH));
    assign accept    = s_tvalid && s_tready;
    // Drop samples with fraction bits when only integers are captured.
    assign drop      = integer_only_reg && (cmd == CMD_SAMPLE)
                       && (s_tdata[FRAC_W-1:0] != '0);
    assign push      = accept && !drop;
    assign q_valid   = (count_reg != 2'd0);
    assign q_op      = queue_mem[rd_ptr_reg];
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integer_only_reg <= 1'b0;
            wr_ptr_reg       <= 1'b0;
            rd_ptr_reg       <= 1'b0;
            count_reg        <= 2'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                integer_only_reg <= cfg_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= '{cmd: cmd, sample: s_tdata};
        end
    end

endmodule

// File: sv/ccb_back.sv
// Execution side: ring storage, counters, dump sequencer and output buffer.
module ccb_back
    import ccb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_valid,
    input  op_t  q_op,
    output logic q_ready,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int ODEPTH = 2;

    bk_state_t     state_reg, state_next;
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] tally_reg, tally_next;
    logic [AW-1:0] dump_addr_reg, dump_addr_next;
    logic [CW-1:0] remain_reg, remain_next;

    logic          slot_valid_reg, slot_count_reg, slot_last_reg;
    logic [CW-1:0] slot_tally_reg;
    logic          issue_valid, issue_count, issue_last;

    logic                ram_we, ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;

    res_t       ofifo_mem [ODEPTH];
    logic       owr_reg, ord_reg;
    logic [1:0] ocnt_reg;
    logic [2:0] occ_after;
    logic       space, opush, opop;
    res_t       opush_res;

    ccb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (q_op.sample),
        .re    (ram_re),
        .raddr (dump_addr_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = (ocnt_reg != 2'd0);
    assign out_res   = ofifo_mem[ord_reg];
    assign opop      = out_valid && out_ready;
    assign opush     = slot_valid_reg;
    // Issue a new result slot only if the output buffer can absorb it next cycle.
    assign occ_after = {1'b0, ocnt_reg} + 3'(opush) - 3'(opop);
    assign space     = (occ_after < 3'(ODEPTH));

    always_comb
    begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        fill_next      = fill_reg;
        tally_next     = tally_reg;
        dump_addr_next = dump_addr_reg;
        remain_next    = remain_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        issue_valid    = 1'b0;
        issue_count    = 1'b0;
        issue_last     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_op.cmd)
                        CMD_SAMPLE:
                        begin
                            q_ready   = 1'b1;
                            ram_we    = 1'b1;
                            wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
                            if (fill_reg != CW'(DEPTH))
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            if (tally_reg != CW'(DEPTH))
                            begin
                                tally_next = tally_reg + 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            q_ready   = 1'b1;
                            wptr_next = '0;
                            fill_next = '0;
                        end
                        CMD_COUNT:
                        begin
                            if (space)
                            begin
                                q_ready     = 1'b1;
                                issue_valid = 1'b1;
                                issue_count = 1'b1;
                                issue_last  = 1'b1;
                                tally_next  = '0;
                            end
                        end
                        CMD_DUMP:
                        begin
                            q_ready = 1'b1;
                            if (fill_reg != '0)
                            begin
                                state_next     = BK_DUMP;
                                remain_next    = fill_reg;
                                // Full ring: oldest entry sits at the write pointer.
                                dump_addr_next = (fill_reg == CW'(DEPTH)) ? wptr_reg : '0;
                            end
                        end
                        default:
                        begin
                            q_ready = 1'b1;
                        end
                    endcase
                end
            end
            BK_DUMP:
            begin
                if (space)
                begin
                    ram_re         = 1'b1;
                    issue_valid    = 1'b1;
                    issue_last     = (remain_reg == CW'(1));
                    remain_next    = remain_reg - 1'b1;
                    dump_addr_next = (dump_addr_reg == AW'(DEPTH - 1)) ?
                                     '0 : dump_addr_reg + 1'b1;
                    if (remain_reg == CW'(1))
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        opush_res.kind  = slot_count_reg ? KIND_COUNT : KIND_DUMP;
        opush_res.value = slot_count_reg ? '0 : ram_rdata;
        opush_res.tally = slot_count_reg ? TALLY_W'(slot_tally_reg) : '0;
        opush_res.last  = slot_last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            wptr_reg       <= '0;
            fill_reg       <= '0;
            tally_reg      <= '0;
            dump_addr_reg  <= '0;
            remain_reg     <= '0;
            slot_valid_reg <= 1'b0;
            owr_reg        <= 1'b0;
            ord_reg        <= 1'b0;
            ocnt_reg       <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            wptr_reg       <= wptr_next;
            fill_reg       <= fill_next;
            tally_reg      <= tally_next;
            dump_addr_reg  <= dump_addr_next;
            remain_reg     <= remain_next;
            slot_valid_reg <= issue_valid;
            owr_reg        <= opush ? ~owr_reg : owr_reg;
            ord_reg        <= opop ? ~ord_reg : ord_reg;
            ocnt_reg       <= 2'(occ_after);
        end
    end

    always_ff @(posedge clk)
    begin
        slot_count_reg <= issue_count;
        slot_last_reg  <= issue_last;
        slot_tally_reg <= tally_reg;
        if (opush)
        begin
            ofifo_mem[owr_reg] <= opush_res;
        end
    end

endmodule

// File: sv/circular_capture_buffer_core.sv
// Top level of the circular capture buffer: front, command queue and back.
//
// Use: items enter on the s_ channel; the command (0 sample, 1 clear,
// 2 count query, 3 dump) rides in s_tuser and the signed Q24.8 sample in
// s_tdata. Results leave on the m_ channel: m_tuser is the kind (0 stored
// value, 1 capture count), m_tdata holds value and tally, m_tlast marks the
// final result of a dump or count. cfg_data sets integer_only, which drops
// samples with nonzero fraction bits; write it only while the block is idle.
// Throughput: one sample or clear per cycle while no dump is running. A dump
// of N entries emits one result per cycle after its start while the receiver
// keeps up, paced by the single RAM read port. Count and dump results pass
// the command queue, a slot register and the output buffer before m_tvalid
// rises; a dump also waits for its start and for the registered RAM read.
// Commands wait in a two-entry queue while a dump is running.
// Reset empties the ring, clears pointer, fill count, tally and
// integer_only; stored samples are not cleared. A stalled receiver stops
// the dump sequencer, then the queue fills and s_tready drops.
module circular_capture_buffer_core
    import ccb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  logic [CMD_W-1:0]    s_tuser,   // [1:0] command
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [31:0] value, [38:32] tally, [39] zero
    output logic                m_tuser,   // [0] kind
    output logic                m_tlast,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data   // [0] integer_only
);

    logic q_valid, q_ready;
    op_t  q_op;
    res_t out_res;

    ccb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_ready   (q_ready)
    );

    ccb_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_ready   (q_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {1'b0, out_res.tally, out_res.value};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

// File: test/ccb_checker.sv
// Checker for the circular capture buffer: tracks the ring, predicts results, compares them.
`timescale 1ns / 1ps

module ccb_checker
    import ccb_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,   // [31:0] sample
    input  logic [CMD_W-1:0]    s_tuser,   // [1:0] command
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [39:0]         m_tdata,   // [31:0] value, [38:32] tally, [39] zero
    input  logic                m_tuser,   // [0] kind
    input  logic                m_tlast,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic                cfg_data,  // [0] integer_only
    output int                  fail_count,
    output int                  pending,
    output int                  checked
);

    logic [SAMPLE_W-1:0] ring [DEPTH];
    int                  wr_ptr;
    int                  fill;
    int                  tally;
    logic                int_only;
    res_t                due_results [$];
    int                  fails = 0;
    int                  seen  = 0;
    int                  pending_r = 0;

    assign fail_count = fails;
    assign pending    = pending_r;
    assign checked    = seen;

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] MISMATCH %s: got 0x%08h, want 0x%08h", $realtime, what, got, want);
        fails++;
    endtask

    // Apply one accepted item to the ring and queue the results it causes.
    task automatic capture_item(cmd_t cmd, logic [SAMPLE_W-1:0] smp);
        res_t r;
        int   total;
        int   pos;
        case (cmd)
            CMD_SAMPLE:
            begin
                // drop fractional samples in integer-only mode
                if (!(int_only && smp[FRAC_W-1:0] != '0))
                begin
                    ring[wr_ptr] = smp;
                    wr_ptr = (wr_ptr == DEPTH - 1) ? 0 : wr_ptr + 1;
                    if (fill < DEPTH)
                        fill++;
                    if (tally < DEPTH)
                        tally++;
                end
            end
            CMD_CLEAR:
            begin
                wr_ptr = 0;
                fill   = 0;
            end
            CMD_COUNT:
            begin
                r.kind  = KIND_COUNT;
                r.value = '0;
                r.tally = TALLY_W'(tally);
                r.last  = 1'b1;
                due_results.push_back(r);
                tally = 0;
            end
            default:
            begin
                if (fill < DEPTH)
                begin
                    total = fill;
                    pos   = 0;
                end
                else
                begin
                    total = DEPTH;
                    pos   = wr_ptr;
                end
                for (int i = 0; i < total; i++)
                begin
                    r.kind  = KIND_DUMP;
                    r.value = ring[pos];
                    r.tally = '0;
                    r.last  = (i == total - 1);
                    due_results.push_back(r);
                    pos = (pos + 1) % DEPTH;
                end
            end
        endcase
    endtask

    task automatic match_result();
        res_t want;
        if (due_results.size() == 0)
        begin
            report_mismatch("unexpected result", m_tdata[31:0], '0);
        end
        else
        begin
            want = due_results.pop_front();
            if (m_tuser !== want.kind)
                report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
            if (m_tdata[31:0] !== want.value)
                report_mismatch("value", m_tdata[31:0], want.value);
            if (m_tdata[38:32] !== want.tally)
                report_mismatch("tally", 32'(m_tdata[38:32]), 32'(want.tally));
            if (m_tlast !== want.last)
                report_mismatch("last", 32'(m_tlast), 32'(want.last));
        end
        seen++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr   = 0;
            fill     = 0;
            tally    = 0;
            int_only = 1'b0;
            due_results.delete();
            pending_r <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                int_only = cfg_data;
            if (m_tvalid && m_tready)
                match_result();
            if (s_tvalid && s_tready)
                capture_item(cmd_t'(s_tuser), s_tdata);
            pending_r <= due_results.size();
        end
    end

endmodule

// File: test/circular_capture_buffer_core_tb.sv
// Testbench top for the circular capture buffer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module circular_capture_buffer_core_tb
    import ccb_pkg::*;
();

    localparam int DEPTH      = 64;
    localparam int CLK_PERIOD = 12;
    localparam int SETTLE     = 12;
    localparam int MAX_CYCLES = 600000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [SAMPLE_W-1:0] s_tdata   = '0;
    logic [CMD_W-1:0]    s_tuser   = '0;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_data  = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [39:0]         m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_ready;

    int snd_idle = 0;
    int rcv_idle = 0;
    int n_items  = 0;
    int n_cfg    = 0;
    int fail_count;
    int pending;
    int checked;

    always #(CLK_PERIOD / 2.0) clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= rcv_idle);

    circular_capture_buffer_core #(.DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ccb_checker #(.DEPTH(DEPTH)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    initial
    begin
        #(CLK_PERIOD * MAX_CYCLES);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one item, idling first at random; valid stays high on return.
    task automatic push_item(cmd_t cmd, logic [SAMPLE_W-1:0] smp);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_tready);
        n_items++;
    endtask

    // Hold off the sender until every queued result has arrived, then settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_mode(logic int_only);
        cfg_valid <= 1'b1;
        cfg_data  <= int_only;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    function automatic logic [SAMPLE_W-1:0] rand_sample(int frac_pct);
        logic [SAMPLE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 99) >= frac_pct)
            v[FRAC_W-1:0] = '0;
        return v;
    endfunction

    task automatic run_phase(int s_idle, int r_idle, logic int_only);
        int burst;
        int frac_pct;
        int pick;
        drain();
        write_mode(int_only);
        snd_idle = s_idle;
        rcv_idle = r_idle;
        frac_pct = int_only ? 12 : 50;
        // fill to at least the depth to wrap the ring and saturate both counters when no samples are dropped
        burst = $urandom_range(DEPTH, DEPTH + 26);
        for (int i = 0; i < burst; i++)
            push_item(CMD_SAMPLE, rand_sample(frac_pct));
        push_item(CMD_DUMP, $urandom);
        push_item(CMD_COUNT, $urandom);
        for (int i = 0; i < 25; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                push_item(CMD_SAMPLE, rand_sample(frac_pct));
            else if (pick < 78)
                push_item(CMD_CLEAR, $urandom);
            else if (pick < 88)
                push_item(CMD_COUNT, $urandom);
            else
            begin
                push_item(CMD_DUMP, $urandom);
                if ($urandom_range(0, 3) == 0)
                    drain();
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        snd_idle = 16;
        rcv_idle = 52;
        write_mode(1'b0);

        // counters right after reset, empty dump, extreme samples
        push_item(CMD_COUNT, 32'h0000_0000);
        push_item(CMD_DUMP, 32'hFFFF_FFFF);
        push_item(CMD_SAMPLE, 32'h7FFF_FFFF);
        push_item(CMD_SAMPLE, 32'h8000_0000);
        push_item(CMD_SAMPLE, 32'h0000_0000);
        push_item(CMD_SAMPLE, 32'hFFFF_FFFF);
        push_item(CMD_SAMPLE, 32'h0000_0100);
        push_item(CMD_DUMP, 32'h0000_0000);
        push_item(CMD_COUNT, 32'h0000_0000);
        push_item(CMD_COUNT, 32'h0000_0000);

        // integer-only mode: fractional samples are dropped
        drain();
        write_mode(1'b1);
        push_item(CMD_SAMPLE, 32'h0000_01FF);
        push_item(CMD_SAMPLE, 32'h0000_0180);
        push_item(CMD_SAMPLE, 32'hFFFF_FF00);
        push_item(CMD_SAMPLE, 32'h0000_0001);
        push_item(CMD_DUMP, 32'h0000_0000);
        push_item(CMD_SAMPLE, 32'h1234_5600);
        // clear keeps the tally, and the dump after it is empty
        push_item(CMD_CLEAR, 32'h0000_0000);
        push_item(CMD_DUMP, 32'h0000_0000);
        push_item(CMD_COUNT, 32'h0000_0000);
        push_item(CMD_SAMPLE, 32'h7FFF_FF00);
        push_item(CMD_DUMP, 32'h0000_0000);

        run_phase(16, 52, 1'b0);
        run_phase(52, 16, 1'b1);
        run_phase(0, 0, 1'b0);
        drain();

        $display("Ran %0d items (samples, clears, count queries, dumps) with %0d mode writes,",
                 n_items, n_cfg);
        $display("covering wrapped and partial rings and saturated tallies; %0d results checked.",
                 checked);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: circular_capture_buffer_core.f
sv/ccb_pkg.sv
sv/ccb_ram.sv
sv/ccb_front.sv
sv/ccb_back.sv
sv/circular_capture_buffer_core.sv
test/ccb_checker.sv
test/circular_capture_buffer_core_tb.sv
